// ===== rtl/tlic_pkg.sv =====
// Package: shared types and constants of the two-level inclusive cache tag model.
`timescale 1ns / 1ps
package tlic_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int L1_WAYS_MAX = 8;
  localparam int L1_SETS_MAX = 64;
  localparam int L2_WAYS_MAX = 16;
  localparam int L2_SETS_MAX = 256;

  localparam int L1_WAY_BITS = $clog2(L1_WAYS_MAX);
  localparam int L1_SET_BITS = $clog2(L1_SETS_MAX);
  localparam int L2_WAY_BITS = $clog2(L2_WAYS_MAX);
  localparam int L2_SET_BITS = $clog2(L2_SETS_MAX);
  localparam int L1_DEPTH    = L1_WAYS_MAX * L1_SETS_MAX;
  localparam int L2_DEPTH    = L2_WAYS_MAX * L2_SETS_MAX;
  localparam int L1_AW       = $clog2(L1_DEPTH);
  localparam int L2_AW       = $clog2(L2_DEPTH);
  localparam int AGE_W       = 16;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 3;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_SIZE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_SIZE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC  = 3'd5;

  typedef struct packed {
    logic [ADDR_BITS-1:0] ba;
    logic                 valid;
    logic                 dirty;
    logic [AGE_W-1:0]     age;
  } line_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_WR_L1HIT,
    ST_WR_L2HIT,
    ST_FILL_L2,
    ST_FILL_L1,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SK_L1_LOOKUP,
    SK_L2_LOOKUP,
    SK_L1_REPLACE,
    SK_L2_WRITEBACK
  } kind_e;

endpackage

// ===== rtl/tlic_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tlic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/two_level_inclusive_cache_model.sv =====
// Top level: two-level inclusive LRU tag cache model with its scan sequencer.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one item: opcode_i (0 read,
//    1 write) and a byte address_i. An item is taken when valid is high and
//    stall is low.
//  - Output channel (out_valid_o / out_stall_i) returns one item per input: the
//    L1 hit / L2 hit / memory flags and the five running totals after it.
//  - Configuration: cfg_we_i with cfg_index_i and cfg_data_i writes a register;
//    write only while no item is in flight. Lines are not cleared by it.
//  - Steps: each way of a scanned set takes a RAM read, then an update write,
//    on the shared age/compare unit. An L1 read hit runs the idle accept step,
//    the L1 scan and a result step; an L1 miss adds the L2 scan, an L2
//    eviction an L1 replace scan that stops at a match, a dirty L1 victim an
//    L2 write-back scan, and each line fill or dirty update its own step. The
//    reset geometry has 2 L1 ways and 4 L2 ways.
//  - One item at a time: in_stall_o is high from acceptance until the result
//    is loaded into the output register; the next item may then enter while
//    that result still waits.
//  - Reset: a clearing pass writes every L1 and L2 line to zero, one entry of
//    each RAM per cycle, with in_stall_o high.
//  - If the receiver stalls, the result holds in the output register and the
//    following item waits in its final step until the register is free.
module two_level_inclusive_cache_model
  import tlic_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [ADDR_BITS-1:0] address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 l1_hit_o,
  output logic                 l2_hit_o,
  output logic                 memory_access_o,
  output logic [31:0]          l1_access_count_o,
  output logic [31:0]          l1_hit_count_o,
  output logic [31:0]          l2_access_count_o,
  output logic [31:0]          l2_hit_count_o,
  output logic [31:0]          memory_access_count_o
);

  // Configuration registers
  logic [3:0] bob_q;
  logic [4:0] l1_size_q;
  logic [1:0] l1_ways_q;
  logic [4:0] l2_size_q;
  logic [2:0] l2_ways_q;
  logic       walloc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bob_q     <= 4'd4;
      l1_size_q <= 5'd10;
      l1_ways_q <= 2'd1;
      l2_size_q <= 5'd14;
      l2_ways_q <= 3'd2;
      walloc_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLOCK_OFFSET: bob_q     <= cfg_data_i[3:0];
        CFG_L1_SIZE:      l1_size_q <= cfg_data_i;
        CFG_L1_WAYS:      l1_ways_q <= cfg_data_i[1:0];
        CFG_L2_SIZE:      l2_size_q <= cfg_data_i;
        CFG_L2_WAYS:      l2_ways_q <= cfg_data_i[2:0];
        CFG_WRITE_ALLOC:  walloc_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Geometry: set masks and last way of each level
  logic signed [6:0]     s1, s2;
  logic [2:0]            sb1;
  logic [3:0]            sb2;
  logic [2:0]            wl2;
  logic [L1_SET_BITS-1:0] mask1;
  logic [L2_SET_BITS-1:0] mask2;
  logic [L1_WAY_BITS-1:0] last1;
  logic [L2_WAY_BITS-1:0] last2;

  always_comb begin
    s1 = $signed({2'b0, l1_size_q}) - $signed({3'b0, bob_q}) - $signed({5'b0, l1_ways_q});
    s2 = $signed({2'b0, l2_size_q}) - $signed({3'b0, bob_q}) - $signed({4'b0, l2_ways_q});
    if (s1 < 0) begin
      sb1 = 3'd0;
    end else if (s1 > 7'(L1_SET_BITS)) begin
      sb1 = 3'(L1_SET_BITS);
    end else begin
      sb1 = s1[2:0];
    end
    if (s2 < 0) begin
      sb2 = 4'd0;
    end else if (s2 > 7'(L2_SET_BITS)) begin
      sb2 = 4'(L2_SET_BITS);
    end else begin
      sb2 = s2[3:0];
    end
    wl2   = (l2_ways_q > 3'(L2_WAY_BITS)) ? 3'(L2_WAY_BITS) : l2_ways_q;
    mask1 = ~({L1_SET_BITS{1'b1}} << sb1);
    mask2 = ~({L2_SET_BITS{1'b1}} << sb2);
    last1 = ~({L1_WAY_BITS{1'b1}} << l1_ways_q);
    last2 = ~({L2_WAY_BITS{1'b1}} << wl2);
  end

  // Sequencer state
  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic [L2_WAY_BITS-1:0] way_q, way_d;
  logic [L2_AW-1:0]       clr_q, clr_d;
  logic                   out_valid_q, out_valid_d;
  logic [31:0] l1_acc_q, l1_acc_d, l1_hit_q, l1_hit_d, l2_acc_q, l2_acc_d;
  logic [31:0] l2_hitc_q, l2_hitc_d, mem_cnt_q, mem_cnt_d;

  // Item payload and scan bookkeeping
  logic                   op_q, op_d;
  logic [ADDR_BITS-1:0]   ba_q, ba_d, key_q, key_d;
  logic                   hit_q, hit_d;
  logic [L2_WAY_BITS-1:0] hit_way_q, hit_way_d;
  logic [AGE_W-1:0]       best_age_q, best_age_d;
  logic [L1_WAY_BITS-1:0] l1v_way_q, l1v_way_d;
  logic [ADDR_BITS-1:0]   l1v_ba_q, l1v_ba_d;
  logic                   l1v_valid_q, l1v_valid_d, l1v_dirty_q, l1v_dirty_d;
  logic [L2_WAY_BITS-1:0] l2v_way_q, l2v_way_d;
  logic [ADDR_BITS-1:0]   l2v_ba_q, l2v_ba_d;
  logic                   l2v_valid_q, l2v_valid_d;
  logic                   h1_q, h1_d, h2_q, h2_d, mem_q, mem_d;
  logic                   o_h1_q, o_h1_d, o_h2_q, o_h2_d, o_mem_q, o_mem_d;
  logic [31:0] o_l1_acc_q, o_l1_acc_d, o_l1_hit_q, o_l1_hit_d, o_l2_acc_q, o_l2_acc_d;
  logic [31:0] o_l2_hit_q, o_l2_hit_d, o_mem_cnt_q, o_mem_cnt_d;

  // RAM ports
  logic             l1_we, l2_we;
  logic [L1_AW-1:0] l1_waddr, l1_raddr;
  logic [L2_AW-1:0] l2_waddr, l2_raddr;
  line_t            l1_wdata, l2_wdata, l1_rdata, l2_rdata;

  tlic_ram #(.WIDTH($bits(line_t)), .DEPTH(L1_DEPTH)) u_l1_ram (
    .clk_i   (clk_i),
    .we_i    (l1_we),
    .waddr_i (l1_waddr),
    .wdata_i (l1_wdata),
    .raddr_i (l1_raddr),
    .rdata_o (l1_rdata)
  );

  tlic_ram #(.WIDTH($bits(line_t)), .DEPTH(L2_DEPTH)) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (l2_waddr),
    .wdata_i (l2_wdata),
    .raddr_i (l2_raddr),
    .rdata_o (l2_rdata)
  );

  // Shared line update unit: compare, age, victim select
  logic                   on_l1, is_lookup, match, last_way, hit_now, out_free, alloc;
  line_t                  rd_line, new_line, fill_line;
  logic [L1_SET_BITS-1:0] key_set1, ba_set1;
  logic [L2_SET_BITS-1:0] key_set2, ba_set2;
  logic [AGE_W-1:0]       age_inc;

  always_comb begin
    on_l1     = (kind_q == SK_L1_LOOKUP) || (kind_q == SK_L1_REPLACE);
    is_lookup = (kind_q != SK_L1_REPLACE);
    rd_line   = on_l1 ? l1_rdata : l2_rdata;
    key_set1  = key_q[L1_SET_BITS-1:0] & mask1;
    key_set2  = key_q[L2_SET_BITS-1:0] & mask2;
    ba_set1   = ba_q[L1_SET_BITS-1:0] & mask1;
    ba_set2   = ba_q[L2_SET_BITS-1:0] & mask2;
    match     = rd_line.valid && (rd_line.ba == key_q);
    age_inc   = (rd_line.age == AGE_MAX) ? AGE_MAX : rd_line.age + 1'b1;
    new_line  = rd_line;
    if (match) begin
      new_line.age   = '0;
      new_line.dirty = rd_line.dirty | (kind_q == SK_L2_WRITEBACK);
    end else begin
      new_line.age = age_inc;
    end
    last_way  = on_l1 ? (way_q == L2_WAY_BITS'(last1)) : (way_q == last2);
    hit_now   = hit_q | match;
    alloc     = !op_q || walloc_q;
    out_free  = !out_valid_q || !out_stall_i;
    fill_line = '{ba: ba_q, valid: 1'b1, dirty: op_q, age: '0};
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    way_d       = way_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q & out_stall_i;
    l1_acc_d    = l1_acc_q;
    l1_hit_d    = l1_hit_q;
    l2_acc_d    = l2_acc_q;
    l2_hitc_d   = l2_hitc_q;
    mem_cnt_d   = mem_cnt_q;
    op_d        = op_q;
    ba_d        = ba_q;
    key_d       = key_q;
    hit_d       = hit_q;
    hit_way_d   = hit_way_q;
    best_age_d  = best_age_q;
    l1v_way_d   = l1v_way_q;
    l1v_ba_d    = l1v_ba_q;
    l1v_valid_d = l1v_valid_q;
    l1v_dirty_d = l1v_dirty_q;
    l2v_way_d   = l2v_way_q;
    l2v_ba_d    = l2v_ba_q;
    l2v_valid_d = l2v_valid_q;
    h1_d        = h1_q;
    h2_d        = h2_q;
    mem_d       = mem_q;
    o_h1_d      = o_h1_q;
    o_h2_d      = o_h2_q;
    o_mem_d     = o_mem_q;
    o_l1_acc_d  = o_l1_acc_q;
    o_l1_hit_d  = o_l1_hit_q;
    o_l2_acc_d  = o_l2_acc_q;
    o_l2_hit_d  = o_l2_hit_q;
    o_mem_cnt_d = o_mem_cnt_q;

    l1_we    = 1'b0;
    l2_we    = 1'b0;
    l1_waddr = {way_q[L1_WAY_BITS-1:0], key_set1};
    l2_waddr = {way_q, key_set2};
    l1_raddr = {way_q[L1_WAY_BITS-1:0], key_set1};
    l2_raddr = {way_q, key_set2};
    l1_wdata = new_line;
    l2_wdata = new_line;

    unique case (state_q)
      ST_CLEAR: begin
        l1_we    = 1'b1;
        l2_we    = 1'b1;
        l1_waddr = clr_q[L1_AW-1:0];
        l2_waddr = clr_q;
        l1_wdata = '0;
        l2_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == L2_AW'(L2_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          ba_d    = address_i >> bob_q;
          key_d   = address_i >> bob_q;
          kind_d  = SK_L1_LOOKUP;
          way_d   = '0;
          hit_d   = 1'b0;
          h1_d    = 1'b0;
          h2_d    = 1'b0;
          mem_d   = 1'b0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_WR;
      end
      ST_SCAN_WR: begin
        // Write back the aged line, or the new block on a replace match
        if (is_lookup) begin
          l1_we = on_l1;
          l2_we = !on_l1;
        end else begin
          l1_we    = match;
          l1_wdata = fill_line;
        end
        if (is_lookup && match) begin
          hit_d     = 1'b1;
          hit_way_d = way_q;
        end
        // Victim: lowest way with the greatest age after aging
        if ((way_q == '0) || (new_line.age > best_age_q)) begin
          best_age_d = new_line.age;
          if (kind_q == SK_L1_LOOKUP) begin
            l1v_way_d   = way_q[L1_WAY_BITS-1:0];
            l1v_ba_d    = rd_line.ba;
            l1v_valid_d = rd_line.valid;
            l1v_dirty_d = rd_line.dirty;
          end
          if (kind_q == SK_L2_LOOKUP) begin
            l2v_way_d   = way_q;
            l2v_ba_d    = rd_line.ba;
            l2v_valid_d = rd_line.valid;
          end
        end
        if (last_way || (!is_lookup && match)) begin
          unique case (kind_q)
            SK_L1_LOOKUP: begin
              if (hit_now) begin
                h1_d    = 1'b1;
                state_d = op_q ? ST_WR_L1HIT : ST_DONE;
              end else begin
                kind_d  = SK_L2_LOOKUP;
                way_d   = '0;
                hit_d   = 1'b0;
                state_d = ST_SCAN_RD;
              end
            end
            SK_L2_LOOKUP: begin
              if (hit_now) begin
                h2_d    = 1'b1;
                state_d = alloc ? ST_FILL_L1 : ST_WR_L2HIT;
              end else begin
                mem_d   = 1'b1;
                state_d = alloc ? ST_FILL_L2 : ST_DONE;
              end
            end
            SK_L1_REPLACE: begin
              state_d = match ? ST_DONE : ST_FILL_L1;
            end
            SK_L2_WRITEBACK: begin
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end else begin
          way_d   = way_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_WR_L1HIT: begin
        l1_we    = 1'b1;
        l1_waddr = {hit_way_q[L1_WAY_BITS-1:0], ba_set1};
        l1_wdata = '{ba: ba_q, valid: 1'b1, dirty: 1'b1, age: '0};
        state_d  = ST_DONE;
      end
      ST_WR_L2HIT: begin
        l2_we    = 1'b1;
        l2_waddr = {hit_way_q, ba_set2};
        l2_wdata = '{ba: ba_q, valid: 1'b1, dirty: 1'b1, age: '0};
        state_d  = ST_DONE;
      end
      ST_FILL_L2: begin
        l2_we    = 1'b1;
        l2_waddr = {l2v_way_q, ba_set2};
        l2_wdata = '{ba: ba_q, valid: 1'b1, dirty: 1'b0, age: '0};
        if (l2v_valid_q) begin
          // Look for the evicted L2 block in L1 to overwrite in place
          kind_d  = SK_L1_REPLACE;
          key_d   = l2v_ba_q;
          way_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_FILL_L1;
        end
      end
      ST_FILL_L1: begin
        l1_we    = 1'b1;
        l1_waddr = {l1v_way_q, ba_set1};
        l1_wdata = fill_line;
        if (l1v_valid_q && l1v_dirty_q) begin
          kind_d  = SK_L2_WRITEBACK;
          key_d   = l1v_ba_q;
          way_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          l1_acc_d    = l1_acc_q + 32'd1;
          l1_hit_d    = l1_hit_q + 32'(h1_q);
          l2_acc_d    = l2_acc_q + 32'(!h1_q);
          l2_hitc_d   = l2_hitc_q + 32'(h2_q);
          mem_cnt_d   = mem_cnt_q + 32'(mem_q);
          o_h1_d      = h1_q;
          o_h2_d      = h2_q;
          o_mem_d     = mem_q;
          o_l1_acc_d  = l1_acc_q + 32'd1;
          o_l1_hit_d  = l1_hit_q + 32'(h1_q);
          o_l2_acc_d  = l2_acc_q + 32'(!h1_q);
          o_l2_hit_d  = l2_hitc_q + 32'(h2_q);
          o_mem_cnt_d = mem_cnt_q + 32'(mem_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      kind_q      <= SK_L1_LOOKUP;
      way_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      l1_acc_q    <= '0;
      l1_hit_q    <= '0;
      l2_acc_q    <= '0;
      l2_hitc_q   <= '0;
      mem_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      way_q       <= way_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      l1_acc_q    <= l1_acc_d;
      l1_hit_q    <= l1_hit_d;
      l2_acc_q    <= l2_acc_d;
      l2_hitc_q   <= l2_hitc_d;
      mem_cnt_q   <= mem_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    ba_q        <= ba_d;
    key_q       <= key_d;
    hit_q       <= hit_d;
    hit_way_q   <= hit_way_d;
    best_age_q  <= best_age_d;
    l1v_way_q   <= l1v_way_d;
    l1v_ba_q    <= l1v_ba_d;
    l1v_valid_q <= l1v_valid_d;
    l1v_dirty_q <= l1v_dirty_d;
    l2v_way_q   <= l2v_way_d;
    l2v_ba_q    <= l2v_ba_d;
    l2v_valid_q <= l2v_valid_d;
    h1_q        <= h1_d;
    h2_q        <= h2_d;
    mem_q       <= mem_d;
    o_h1_q      <= o_h1_d;
    o_h2_q      <= o_h2_d;
    o_mem_q     <= o_mem_d;
    o_l1_acc_q  <= o_l1_acc_d;
    o_l1_hit_q  <= o_l1_hit_d;
    o_l2_acc_q  <= o_l2_acc_d;
    o_l2_hit_q  <= o_l2_hit_d;
    o_mem_cnt_q <= o_mem_cnt_d;
  end

  assign in_stall_o            = (state_q != ST_IDLE);
  assign out_valid_o           = out_valid_q;
  assign l1_hit_o              = o_h1_q;
  assign l2_hit_o              = o_h2_q;
  assign memory_access_o       = o_mem_q;
  assign l1_access_count_o     = o_l1_acc_q;
  assign l1_hit_count_o        = o_l1_hit_q;
  assign l2_access_count_o     = o_l2_acc_q;
  assign l2_hit_count_o        = o_l2_hit_q;
  assign memory_access_count_o = o_mem_cnt_q;

`ifndef SYNTHESIS
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({l1_hit_o, l2_hit_o, memory_access_o}))
    else $error("result must carry exactly one outcome");

  a_l1_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (l1_hit_count_o + l2_access_count_o == l1_access_count_o))
    else $error("L1 hits plus L2 accesses must equal L1 accesses");

  a_l2_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (l2_hit_count_o + memory_access_count_o == l2_access_count_o))
    else $error("L2 hits plus memory accesses must equal L2 accesses");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCAN_RD && kind_q == SK_L1_LOOKUP))
    else $error("accepted item must start the L1 lookup");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> (state_q == ST_DONE))
    else $error("finished item must hold while the output register is full");
`endif

endmodule
